FILE: rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Shared types and constants for the unit normal pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  localparam int unsigned TAG_W = 16;
  localparam int unsigned LANES = 3;

  // Per-request data that rides beside the arithmetic.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LANES-1:0] neg;
    logic             degen;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/tun_root_step.sv
// ----------------------------------------------------------------------------
// Root step
// One registered digit step of the scaled square root, three lanes sharing
// the squared length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_root_step
  import tun_pkg::*;
#(
  parameter int unsigned K   = 0,
  parameter int unsigned SSW = 84,
  parameter int unsigned PW  = 100,
  parameter int unsigned RW  = 116,
  parameter int unsigned TW  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  side_t                      side_i,
  input  logic [SSW-1:0]             s_i,
  input  logic [LANES-1:0][RW-1:0]   rem_i,
  input  logic [LANES-1:0][PW-1:0]   p_i,
  input  logic [LANES-1:0][TW-1:0]   t_i,
  output logic                       valid_o,
  output side_t                      side_o,
  output logic [SSW-1:0]             s_o,
  output logic [LANES-1:0][RW-1:0]   rem_o,
  output logic [LANES-1:0][PW-1:0]   p_o,
  output logic [LANES-1:0][TW-1:0]   t_o
);

  logic [LANES-1:0][RW-1:0] rem_d;
  logic [LANES-1:0][PW-1:0] p_d;
  logic [LANES-1:0][TW-1:0] t_d;

  // With P = t*S, setting bit K of t costs S*(t*2^(K+1) + 4^K).
  always_comb begin
    logic [RW-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = (RW'(p_i[l]) << (K + 1)) + (RW'(s_i) << (2 * K));
      if (rem_i[l] >= trial) begin
        rem_d[l] = rem_i[l] - trial;
        p_d[l]   = p_i[l] + (PW'(s_i) << K);
        t_d[l]   = t_i[l] | (TW'(1) << K);
      end else begin
        rem_d[l] = rem_i[l];
        p_d[l]   = p_i[l];
        t_d[l]   = t_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    s_o    <= s_i;
    rem_o  <= rem_d;
    p_o    <= p_d;
    t_o    <= t_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Pipelined unit surface normal of a triangle in signed fixed point.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start_i high and busy_o low; busy_o
// is always low, so one triangle may enter every cycle. Each vertex has x,
// depth y and height h; x and y are scaled by 5 before the edge vectors and
// their cross product are formed. The normal is divided by its length with
// NORMAL_FRAC_BITS fraction bits, rounded to nearest, ties away from zero.
// The result appears on the result ports for one cycle with done_o high, in
// request order, with the tag echoed. Registered stages form the edge
// vectors, cross product and squared length; one digit-recurrence root step
// per cycle, NORMAL_FRAC_BITS + 2 of them, finds each rounded component; a
// final register stage applies sign and rounding. A zero cross product gives
// zero components with degenerate_o set. The receiver cannot hold off
// results. Reset empties the pipeline; requests in flight are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal
  import tun_pkg::*;
#(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [TAG_W-1:0]                    tag_i,
  input  logic signed [COORD_WIDTH-1:0]       ax_i,
  input  logic signed [COORD_WIDTH-1:0]       ay_i,
  input  logic signed [COORD_WIDTH-1:0]       ah_i,
  input  logic signed [COORD_WIDTH-1:0]       bx_i,
  input  logic signed [COORD_WIDTH-1:0]       by_i,
  input  logic signed [COORD_WIDTH-1:0]       bh_i,
  input  logic signed [COORD_WIDTH-1:0]       cx_i,
  input  logic signed [COORD_WIDTH-1:0]       cy_i,
  input  logic signed [COORD_WIDTH-1:0]       ch_i,
  output logic                                done_o,
  output logic [TAG_W-1:0]                    tag_out_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]  nx_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]  ny_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]  nz_o,
  output logic                                degenerate_o
);

  localparam int unsigned F    = NORMAL_FRAC_BITS;
  localparam int unsigned SW   = COORD_WIDTH + 3;    // scaled coordinate
  localparam int unsigned DW   = SW + 1;             // edge component
  localparam int unsigned MW   = 2 * DW;             // edge product
  localparam int unsigned CRW  = MW + 1;             // cross component
  localparam int unsigned H    = (CRW + 1) / 2;      // low half of magnitude
  localparam int unsigned HW   = CRW - H;            // high half of magnitude
  localparam int unsigned SQW  = 2 * CRW;            // squared component
  localparam int unsigned SSW  = SQW + 2;            // squared length
  localparam int unsigned TW   = F + 2;              // root digits
  localparam int unsigned PW   = SSW + TW;
  localparam int unsigned RW   = SSW + 2 * F + 4;
  localparam int unsigned NSTEP = TW;
  localparam int unsigned OW   = F + 2;
  localparam int unsigned LAT  = 7 + NSTEP;

  assign busy_o = 1'b0;

  // Stage 1: scaled edge vectors, lanes ordered x, h, y.
  logic               v1_q;
  side_t              sd1_q;
  logic signed [DW-1:0] u_q [LANES];
  logic signed [DW-1:0] w_q [LANES];

  logic signed [SW-1:0] ax5, ay5, bx5, by5, cx5, cy5;
  assign ax5 = (SW'(ax_i) <<< 2) + SW'(ax_i);
  assign ay5 = (SW'(ay_i) <<< 2) + SW'(ay_i);
  assign bx5 = (SW'(bx_i) <<< 2) + SW'(bx_i);
  assign by5 = (SW'(by_i) <<< 2) + SW'(by_i);
  assign cx5 = (SW'(cx_i) <<< 2) + SW'(cx_i);
  assign cy5 = (SW'(cy_i) <<< 2) + SW'(cy_i);

  always_ff @(posedge clk_i) begin
    sd1_q.tag   <= tag_i;
    sd1_q.neg   <= '0;
    sd1_q.degen <= 1'b0;
    u_q[0] <= DW'(bx5) - DW'(ax5);
    u_q[1] <= DW'(bh_i) - DW'(ah_i);
    u_q[2] <= DW'(by5) - DW'(ay5);
    w_q[0] <= DW'(cx5) - DW'(ax5);
    w_q[1] <= DW'(ch_i) - DW'(ah_i);
    w_q[2] <= DW'(cy5) - DW'(ay5);
  end

  // Stage 2: the six products of the cross product.
  logic                 v2_q;
  side_t                sd2_q;
  logic signed [MW-1:0] pa_q [LANES];
  logic signed [MW-1:0] pb_q [LANES];

  always_ff @(posedge clk_i) begin
    sd2_q   <= sd1_q;
    pa_q[0] <= u_q[1] * w_q[2];
    pb_q[0] <= u_q[2] * w_q[1];
    pa_q[1] <= u_q[2] * w_q[0];
    pb_q[1] <= u_q[0] * w_q[2];
    pa_q[2] <= u_q[0] * w_q[1];
    pb_q[2] <= u_q[1] * w_q[0];
  end

  // Stage 3: cross product as sign and magnitude.
  logic              v3_q;
  side_t             sd3_q;
  logic [CRW-1:0]    mag_q [LANES];
  logic [CRW-1:0]    cr   [LANES];
  logic [LANES-1:0]  cr_neg;
  logic [LANES-1:0]  cr_zero;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cr[l]      = CRW'(pa_q[l]) - CRW'(pb_q[l]);
      cr_neg[l]  = cr[l][CRW-1];
      cr_zero[l] = (cr[l] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    sd3_q.tag   <= sd2_q.tag;
    sd3_q.neg   <= cr_neg;
    sd3_q.degen <= &cr_zero;
    for (int l = 0; l < LANES; l++) begin
      mag_q[l] <= cr_neg[l] ? (~cr[l] + CRW'(1)) : cr[l];
    end
  end

  // Stage 4: partial products of each square, split in halves.
  logic              v4_q;
  side_t             sd4_q;
  logic [2*HW-1:0]   hh_q [LANES];
  logic [HW+H-1:0]   hl_q [LANES];
  logic [2*H-1:0]    ll_q [LANES];

  always_ff @(posedge clk_i) begin
    sd4_q <= sd3_q;
    for (int l = 0; l < LANES; l++) begin
      hh_q[l] <= mag_q[l][CRW-1:H] * mag_q[l][CRW-1:H];
      hl_q[l] <= mag_q[l][CRW-1:H] * mag_q[l][H-1:0];
      ll_q[l] <= mag_q[l][H-1:0] * mag_q[l][H-1:0];
    end
  end

  // Stage 5: squared components.
  logic           v5_q;
  side_t          sd5_q;
  logic [SQW-1:0] sq_q [LANES];

  always_ff @(posedge clk_i) begin
    sd5_q <= sd4_q;
    for (int l = 0; l < LANES; l++) begin
      sq_q[l] <= (SQW'(hh_q[l]) << (2 * H)) + (SQW'(hl_q[l]) << (H + 1))
               + SQW'(ll_q[l]);
    end
  end

  // Stage 6: squared length and the initial remainders c^2 * 4^(F+1).
  logic                     v6_q;
  side_t                    sd6_q;
  logic [SSW-1:0]           s6_q;
  logic [LANES-1:0][RW-1:0] rem6_q;

  always_ff @(posedge clk_i) begin
    sd6_q <= sd5_q;
    s6_q  <= SSW'(sq_q[0]) + SSW'(sq_q[1]) + SSW'(sq_q[2]);
    for (int l = 0; l < LANES; l++) begin
      rem6_q[l] <= RW'(sq_q[l]) << (2 * F + 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Root steps: largest t with t^2 * S <= c^2 * 4^(F+1), one digit a stage.
  logic                     st_v   [NSTEP+1];
  side_t                    st_sd  [NSTEP+1];
  logic [SSW-1:0]           st_s   [NSTEP+1];
  logic [LANES-1:0][RW-1:0] st_rem [NSTEP+1];
  logic [LANES-1:0][PW-1:0] st_p   [NSTEP+1];
  logic [LANES-1:0][TW-1:0] st_t   [NSTEP+1];

  assign st_v[0]   = v6_q;
  assign st_sd[0]  = sd6_q;
  assign st_s[0]   = s6_q;
  assign st_rem[0] = rem6_q;
  assign st_p[0]   = '0;
  assign st_t[0]   = '0;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    tun_root_step #(
      .K   (NSTEP - 1 - g),
      .SSW (SSW),
      .PW  (PW),
      .RW  (RW),
      .TW  (TW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_v[g]),
      .side_i  (st_sd[g]),
      .s_i     (st_s[g]),
      .rem_i   (st_rem[g]),
      .p_i     (st_p[g]),
      .t_i     (st_t[g]),
      .valid_o (st_v[g+1]),
      .side_o  (st_sd[g+1]),
      .s_o     (st_s[g+1]),
      .rem_o   (st_rem[g+1]),
      .p_o     (st_p[g+1]),
      .t_o     (st_t[g+1])
    );
  end

  // Output: the rounded magnitude is the largest odd t not above the root,
  // plus one, halved, which equals (t + 1) / 2 for the integer root t.
  logic [OW-1:0] qv [LANES];
  logic [OW-1:0] nv [LANES];
  logic          done_q;
  logic [TAG_W-1:0] tag_q;
  logic [OW-1:0] nx_q, ny_q, nz_q;
  logic          degen_q;

  always_comb begin
    logic [TW:0] tp1;
    for (int l = 0; l < LANES; l++) begin
      tp1   = {1'b0, st_t[NSTEP][l]} + (TW + 1)'(1);
      qv[l] = OW'(tp1 >> 1);
      if (st_sd[NSTEP].degen) begin
        nv[l] = '0;
      end else if (st_sd[NSTEP].neg[l]) begin
        nv[l] = ~qv[l] + OW'(1);
      end else begin
        nv[l] = qv[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= st_v[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= st_sd[NSTEP].tag;
    nx_q    <= nv[0];
    ny_q    <= nv[1];
    nz_q    <= nv[2];
    degen_q <= st_sd[NSTEP].degen;
  end

  assign done_o       = done_q;
  assign tag_out_o    = tag_q;
  assign nx_o         = nx_q;
  assign ny_o         = ny_q;
  assign nz_o         = nz_q;
  assign degenerate_o = degen_q;

  localparam logic signed [OW-1:0] ONE  = OW'(1) << F;
  localparam logic signed [OW-1:0] MONE = -(OW'(1) << F);

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o)
    else $error("request did not complete after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching request");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> nx_o == '0 && ny_o == '0 && nz_o == '0)
    else $error("degenerate result with nonzero components");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> nx_o <= ONE && nx_o >= MONE && ny_o <= ONE && ny_o >= MONE
               && nz_o <= ONE && nz_o >= MONE)
    else $error("normal component beyond unit range");

endmodule

`default_nettype wire
